@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/lpfd_pkg.sv @@
// Types, constants and helper functions for the length-prefixed float deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam int unsigned HEADER_BYTES      = 4;
    localparam int unsigned WORD_BYTES        = 4;
    localparam int unsigned LEN_W             = 25;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 25'd16777216;

    // Frame phases: header and payload of each of the two waves.
    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_PAY0 = 2'd1,
        PH_HDR1 = 2'd2,
        PH_PAY1 = 2'd3
    } phase_t;

    // Word byte orders.
    typedef enum logic [1:0] {
        ENC_LE   = 2'd0,
        ENC_BE   = 2'd1,
        ENC_SWAP = 2'd2,
        ENC_RSVD = 2'd3
    } enc_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HEADER_ORDER = 2'd0,
        CFG_WORD_ENC     = 2'd1,
        CFG_MAX_PAYLOAD  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic             header_order;
        logic [1:0]       word_encoding;
        logic [LEN_W-1:0] max_payload_bytes;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic [23:0]      header_window;
        logic [1:0]       header_fill;
        logic [LEN_W-1:0] payload_left;
        logic [23:0]      word_bytes;
        logic [1:0]       word_fill;
        logic [31:0]      frame_counter;
    } state_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic        wave_id;
        logic [31:0] sample_bits;
        logic        last_of_payload;
        logic [31:0] frames_done;
    } result_t;

    // Reverse the byte order of a 32-bit word.
    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Assemble a sample from four bytes held oldest-first in the top byte.
    function automatic logic [31:0] assemble_word(input logic [31:0] w, input logic [1:0] enc);
        logic [31:0] r;
        case (enc)
            ENC_BE:   r = w;
            ENC_SWAP: r = {w[15:8], w[7:0], w[23:16], w[31:24]};
            default:  r = {w[7:0], w[15:8], w[23:16], w[31:24]};
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/lpfd_step.sv @@
// Per-byte next-state and result logic of the deframer.
`timescale 1ns / 1ps

module lpfd_step
(
    input  lpfd_pkg::state_t  cur,
    input  lpfd_pkg::cfg_t    cfg,
    input  logic [7:0]        data_byte,
    output lpfd_pkg::state_t  nxt,
    output lpfd_pkg::result_t res
);
    import lpfd_pkg::*;

    logic [31:0]      hdr_win;
    logic [31:0]      hdr_len;
    logic             hdr_ok;
    logic [LEN_W-1:0] left_dec;
    logic             last;
    logic [31:0]      frames_inc;

    assign hdr_win    = {cur.header_window, data_byte};
    assign hdr_len    = cfg.header_order ? hdr_win : swap_bytes(hdr_win);
    assign hdr_ok     = (hdr_len != 32'd0) && !hdr_len[31]
                        && (hdr_len <= {7'd0, cfg.max_payload_bytes})
                        && (hdr_len[1:0] == 2'b00);
    assign left_dec   = (cur.payload_left != '0) ? cur.payload_left - 1'b1 : cur.payload_left;
    assign last       = (left_dec == '0);
    assign frames_inc = cur.frame_counter + 32'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.wave_id     = cur.phase[1];
        res.frames_done = cur.frame_counter;
        if (!cur.phase[0])
        begin
            // Header: shift the byte into the window, check once four are in
            nxt.header_window = hdr_win[23:0];
            if (cur.header_fill != 2'(HEADER_BYTES - 1))
            begin
                nxt.header_fill = cur.header_fill + 2'd1;
            end
            else if (hdr_ok)
            begin
                nxt.payload_left  = hdr_len[LEN_W-1:0];
                nxt.header_fill   = 2'd0;
                nxt.header_window = '0;
                nxt.word_fill     = 2'd0;
                nxt.word_bytes    = '0;
                nxt.phase         = phase_t'(cur.phase + 2'd1);
            end
            else
            begin
                // Drop the oldest byte and report it
                res.valid       = 1'b1;
                res.kind        = 1'b1;
                res.sample_bits = {24'd0, hdr_win[31:24]};
            end
        end
        else
        begin
            // Payload: collect bytes, emit each complete word
            nxt.payload_left = left_dec;
            if (cur.word_fill != 2'(WORD_BYTES - 1))
            begin
                nxt.word_bytes = {cur.word_bytes[15:0], data_byte};
                nxt.word_fill  = cur.word_fill + 2'd1;
            end
            else
            begin
                nxt.word_fill  = 2'd0;
                nxt.word_bytes = '0;
                res.valid           = 1'b1;
                res.sample_bits     = assemble_word({cur.word_bytes, data_byte},
                                                    cfg.word_encoding);
                res.last_of_payload = last;
                if (last)
                begin
                    if (cur.phase == PH_PAY1)
                    begin
                        nxt.frame_counter = frames_inc;
                        nxt.phase         = PH_HDR0;
                        res.frames_done   = frames_inc;
                    end
                    else
                    begin
                        nxt.phase = PH_HDR1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/core/length_prefixed_float_deframer.sv @@
// Top level of the length-prefixed float deframer.
//
//  channel  dir  payload
//  s_*      in   tdata[7:0] stream_byte
//  m_*      out  tdata[31:0] sample_bits, [63:32] frames_done; tuser kind, wave_id; tlast
//  cfg_*    in   index 0 header_order, 1 word_encoding, 2 max_payload_bytes
//
// One byte per clock while s_tready is high: each byte updates the decoder state in
// the cycle it is accepted; its result, if any, enters the output or skid register.
// A one-entry skid register behind the output keeps s_tready a pure register;
// while the output is held, bytes keep flowing until one more result is taken.
// rst_n clears the decoder state and both output stages and resets the config fields.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefixed_float_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] sample_bits, [63:32] frames_done
    output logic [1:0]  m_tuser,   // [0] kind, [1] wave_id
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);
    import lpfd_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t take_res;
    result_t out_reg;
    result_t skid_reg;
    logic    accept;
    logic    out_free;

    assign s_tready = !skid_reg.valid;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_reg.valid || m_tready;

    lpfd_step u_step
    (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .data_byte (s_tdata),
        .nxt       (state_next),
        .res       (step_res)
    );

    // Gate the step result with the input handshake
    always_comb
    begin
        take_res       = step_res;
        take_res.valid = accept && step_res.valid;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_order      <= 1'b0;
            cfg_reg.word_encoding     <= ENC_LE;
            cfg_reg.max_payload_bytes <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEADER_ORDER: cfg_reg.header_order      <= cfg_data[0];
                CFG_WORD_ENC:     cfg_reg.word_encoding     <= cfg_data[1:0];
                CFG_MAX_PAYLOAD:  cfg_reg.max_payload_bytes <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Decoder state: advance on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_HDR0, default: '0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (out_free)
        begin
            if (skid_reg.valid)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
            else
            begin
                out_reg <= take_res;
            end
        end
        else if (accept && step_res.valid)
        begin
            skid_reg <= step_res;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {out_reg.frames_done, out_reg.sample_bits};
    assign m_tuser  = {out_reg.wave_id, out_reg.kind};
    assign m_tlast  = out_reg.last_of_payload;

    // Skid stage only fills behind a held output transaction
    `ASSERT_IMPLIES(a_skid_behind_out, skid_reg.valid, out_reg.valid)
    // A skipped byte never closes a payload
    `ASSERT_IMPLIES(a_skip_not_last, out_reg.valid && out_reg.kind, !out_reg.last_of_payload)
    // Bytes left and word fill stay aligned to whole words during a payload
    `ASSERT_IMPLIES(a_word_align, state_reg.phase[0],
                    (state_reg.payload_left[1:0] + state_reg.word_fill) == 2'd0)

endmodule
